### rtl/fbd_pkg.sv
// Package for the fractional baud divisor unit: payload structs, widths and constants.
// Depends on nothing; imported by fbd_div_stage, uart_fractional_baud_divisor_unit and the testbench.
`default_nettype none

package fbd_pkg;

    localparam int FBD_IN_W       = 32;   // clock and baud field width
    localparam int FBD_INT_W      = 28;   // integer divisor width
    localparam int FBD_FRAC_W     = 6;    // fractional divisor width
    localparam int FBD_QUOT_W     = FBD_INT_W + FBD_FRAC_W; // floor(4 * clock / baud)
    localparam int FBD_STAGE_BITS = 2;    // quotient bits resolved per pipeline stage

    localparam logic [FBD_FRAC_W-1:0] FBD_FRAC_MAX = '1;

    typedef struct packed {
        logic [FBD_IN_W-1:0] clock_freq_hz;
        logic [FBD_IN_W-1:0] baud_rate;
    } fbd_in_t;

    typedef struct packed {
        logic [FBD_INT_W-1:0]  integer_divisor;
        logic [FBD_FRAC_W-1:0] fraction_divisor;
    } fbd_out_t;

    // Control that travels alongside each item in the divider pipeline.
    typedef struct packed {
        logic valid;
        logic zero;   // clock or baud was zero
    } fbd_ctrl_t;

endpackage

`default_nettype wire

### rtl/fbd_div_stage.sv
// One registered stage of the restoring divider: resolves STAGE_BITS quotient bits.
// Depends on fbd_pkg for the field width and the control struct.
`default_nettype none

module fbd_div_stage #(
    parameter int STAGE_BITS = fbd_pkg::FBD_STAGE_BITS,
    parameter int ACC_W      = fbd_pkg::FBD_QUOT_W
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  fbd_pkg::fbd_ctrl_t          ctrl_in,
    input  wire  [fbd_pkg::FBD_IN_W-1:0]      rem_in,
    input  wire  [fbd_pkg::FBD_IN_W-1:0]      divisor_in,
    input  wire  [ACC_W-1:0]                  acc_in,
    output fbd_pkg::fbd_ctrl_t                ctrl_out,
    output logic [fbd_pkg::FBD_IN_W-1:0]      rem_out,
    output logic [fbd_pkg::FBD_IN_W-1:0]      divisor_out,
    output logic [ACC_W-1:0]                  acc_out
);
    import fbd_pkg::*;

    fbd_ctrl_t           ctrl_reg;
    logic [FBD_IN_W-1:0] rem_reg;
    logic [FBD_IN_W-1:0] rem_next;
    logic [FBD_IN_W-1:0] divisor_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;

    // The accumulator shifts dividend bits out at the top and quotient bits in at the bottom.
    always_comb
    begin
        logic [FBD_IN_W:0]   trial;
        logic [FBD_IN_W-1:0] rem_v;
        logic [ACC_W-1:0]    acc_v;
        rem_v = rem_in;
        acc_v = acc_in;
        for (int k = 0; k < STAGE_BITS; k++)
        begin
            trial = {rem_v, acc_v[ACC_W-1]};
            acc_v = {acc_v[ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_in})
            begin
                trial    = trial - {1'b0, divisor_in};
                acc_v[0] = 1'b1;
            end
            rem_v = trial[FBD_IN_W-1:0];
        end
        rem_next = rem_v;
        acc_next = acc_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_in;
        acc_reg     <= acc_next;
    end

    assign ctrl_out    = ctrl_reg;
    assign rem_out     = rem_reg;
    assign divisor_out = divisor_reg;
    assign acc_out     = acc_reg;

endmodule

`default_nettype wire

### rtl/uart_fractional_baud_divisor_unit.sv
// Top level of the UART fractional baud divisor unit: pipelined divider plus rounding stage.
// Depends on fbd_pkg and fbd_div_stage.
//
//   Channel   Signals                   Transfer happens when
//   -------   -----------------------   ------------------------------------------
//   request   start, busy, request      rising edge with start high and busy low
//   result    done, result              rising edge that ends the cycle done is high
//
// Between the accepting edge and the result strobe lie the 34-bit restoring division,
// spread over the chain of divider stages at two quotient bits per stage by default,
// and one rounding and saturation stage. The result transfer happens at the edge
// that ends the strobe cycle.
// A new request is accepted in every cycle, so busy is always low.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds and results leave in order.
`default_nettype none

module uart_fractional_baud_divisor_unit #(
    parameter int STAGE_BITS = fbd_pkg::FBD_STAGE_BITS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire fbd_pkg::fbd_in_t request,
    output logic                done,
    output fbd_pkg::fbd_out_t   result
);
    import fbd_pkg::*;

    // The divider computes Q = floor(4 * clock / baud) and its remainder r. Then the
    // integer divisor is Q / 64, the truncated fraction is Q mod 64, and the fraction
    // rounds up when 2 * r >= baud, which is the half-denominator rounding of the
    // sixteen-times-baud formulation.
    localparam int NUM_STAGES = (FBD_QUOT_W + STAGE_BITS - 1) / STAGE_BITS;
    localparam int ACC_W      = NUM_STAGES * STAGE_BITS;
    localparam int LATENCY    = NUM_STAGES + 1;

    fbd_ctrl_t           ctrl_s    [0:NUM_STAGES];
    logic [FBD_IN_W-1:0] rem_s     [0:NUM_STAGES];
    logic [FBD_IN_W-1:0] divisor_s [0:NUM_STAGES];
    logic [ACC_W-1:0]    acc_s     [0:NUM_STAGES];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage zero input: the dividend is the clock shifted left by two, zero-extended
    // to fill the whole accumulator; leading zeros only give leading zero quotient bits.
    assign ctrl_s[0]    = '{valid: accept,
                            zero:  (request.clock_freq_hz == '0) || (request.baud_rate == '0)};
    assign rem_s[0]     = '0;
    assign divisor_s[0] = request.baud_rate;
    assign acc_s[0]     = ACC_W'({request.clock_freq_hz, 2'b00});

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_div
        fbd_div_stage #(
            .STAGE_BITS (STAGE_BITS),
            .ACC_W      (ACC_W)
        ) u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl_in     (ctrl_s[g]),
            .rem_in      (rem_s[g]),
            .divisor_in  (divisor_s[g]),
            .acc_in      (acc_s[g]),
            .ctrl_out    (ctrl_s[g+1]),
            .rem_out     (rem_s[g+1]),
            .divisor_out (divisor_s[g+1]),
            .acc_out     (acc_s[g+1])
        );
    end

    // Final stage: split the quotient, round the fraction, saturate it at its maximum
    // without carrying into the integer part, and force the integer part to at least one.
    logic [FBD_QUOT_W-1:0] quot_full;
    logic [FBD_INT_W-1:0]  int_part;
    logic [FBD_FRAC_W-1:0] frac_trunc;
    logic                  round_up;
    logic [FBD_FRAC_W:0]   frac_sum;
    fbd_out_t              result_next;
    fbd_out_t              result_reg;
    logic                  done_reg;

    always_comb
    begin
        quot_full  = acc_s[NUM_STAGES][FBD_QUOT_W-1:0];
        int_part   = quot_full[FBD_QUOT_W-1:FBD_FRAC_W];
        frac_trunc = quot_full[FBD_FRAC_W-1:0];
        round_up   = {rem_s[NUM_STAGES], 1'b0} >= {1'b0, divisor_s[NUM_STAGES]};
        frac_sum   = {1'b0, frac_trunc} + {{FBD_FRAC_W{1'b0}}, round_up};

        if (ctrl_s[NUM_STAGES].zero)
        begin
            result_next.integer_divisor  = FBD_INT_W'(1);
            result_next.fraction_divisor = '0;
        end
        else
        begin
            result_next.integer_divisor  = (int_part == '0) ? FBD_INT_W'(1) : int_part;
            result_next.fraction_divisor = frac_sum[FBD_FRAC_W] ? FBD_FRAC_MAX
                                                                : frac_sum[FBD_FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_s[NUM_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result appears only for a matching earlier accepted transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching request");

    // The integer divisor is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.integer_divisor != '0))
        else $error("integer divisor is zero");

    // A zero baud rate gives integer one and fraction zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(request.baud_rate == '0, LATENCY)) |->
            (result.integer_divisor == FBD_INT_W'(1) && result.fraction_divisor == '0))
        else $error("zero baud rate not handled");

    // A clock below sixteen times the baud rate forces the integer divisor to one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past({4'b0000, request.clock_freq_hz} < {request.baud_rate, 4'b0000},
                       LATENCY)) |->
            (result.integer_divisor == FBD_INT_W'(1)))
        else $error("small clock did not force integer divisor to one");

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for uart_fractional_baud_divisor_unit (integer and fractional divisors).
// Depends on fbd_pkg and the divider RTL; it predicts every result and compares it in order.
`timescale 1ns / 1ps

module testbench;

    import fbd_pkg::*;

    // The drain follows the last outstanding result and watches for stray results
    // before the run is declared finished.
    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1000;
    localparam int IDLE_PERCENT = 10;
    localparam int MAX_GAP      = 4;

    // Arithmetic constants of the divisor calculation.
    localparam longint unsigned OVERSAMPLE = 16;
    localparam longint unsigned FRAC_SCALE = 64;
    localparam longint unsigned HALF_DIV   = 2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    fbd_in_t   request;
    logic      done;
    fbd_out_t  result;

    // Divisors predicted for accepted requests, oldest first.
    fbd_out_t  pending_divisors[$];

    int        failures;
    int        requests_accepted;
    int        divisors_checked;
    int        saturated_fractions;
    int        zero_operand_requests;
    bit        gaps_enabled;

    uart_fractional_baud_divisor_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Safety net: the slowest legal run is well under a hundred microseconds.
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Predicts the divisor pair for one request. The denominator is sixteen times the
    // baud rate; the fraction is the remainder in sixty-fourths, rounded to nearest and
    // then clipped to its largest code instead of carrying into the integer part.
    function automatic fbd_out_t compute_divisors(input fbd_in_t req);
        longint unsigned clk_freq;
        longint unsigned baud;
        longint unsigned denom;
        longint unsigned quotient;
        longint unsigned remainder;
        longint unsigned fraction;
        fbd_out_t        divisors;
        clk_freq = {32'd0, req.clock_freq_hz};
        baud     = {32'd0, req.baud_rate};
        if (clk_freq == 0 || baud == 0)
        begin
            divisors.integer_divisor  = FBD_INT_W'(1);
            divisors.fraction_divisor = '0;
            return divisors;
        end
        denom     = OVERSAMPLE * baud;
        quotient  = clk_freq / denom;
        remainder = clk_freq % denom;
        fraction  = (remainder * FRAC_SCALE + denom / HALF_DIV) / denom;
        // A clock slower than sixteen times the baud still programs a divisor of one.
        if (quotient == 0)
        begin
            quotient = 1;
        end
        if (fraction > longint'(FBD_FRAC_MAX))
        begin
            fraction = longint'(FBD_FRAC_MAX);
        end
        divisors.integer_divisor  = quotient[FBD_INT_W-1:0];
        divisors.fraction_divisor = fraction[FBD_FRAC_W-1:0];
        return divisors;
    endfunction

    // Holds start low for the requested pause. The request bus carries junk meanwhile, which
    // the unit must ignore because no transfer takes place.
    task automatic pause_requests(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= {$urandom, $urandom};
        end
    endtask

    // Presents one request and waits for its transfer. Start is left high afterwards so
    // that back-to-back requests keep it asserted; the next pause or the end lowers it.
    task automatic issue_request(input logic [31:0] clk_freq, input logic [31:0] baud);
        fbd_in_t  req;
        fbd_out_t divisors;
        bit       accepted;
        req.clock_freq_hz = clk_freq;
        req.baud_rate     = baud;
        if (gaps_enabled && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            pause_requests($urandom_range(MAX_GAP, 1));
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = !busy;
        end
        divisors = compute_divisors(req);
        pending_divisors.push_back(divisors);
        requests_accepted++;
        if (clk_freq == 0 || baud == 0)
        begin
            zero_operand_requests++;
        end
        else if (divisors.fraction_divisor == FBD_FRAC_MAX)
        begin
            saturated_fractions++;
        end
    endtask

    // Every result is taken at the edge that ends its strobe cycle and compared with the
    // oldest prediction. Values read here are the ones the edge itself captures.
    always @(posedge clk)
    begin : check_results
        fbd_out_t want;
        if (rst_n && done)
        begin
            if (pending_divisors.size() == 0)
            begin
                $error("result with no request outstanding: %s %0d, %s %0d",
                       "integer_divisor", result.integer_divisor,
                       "fraction_divisor", result.fraction_divisor);
                failures++;
            end
            else
            begin
                want = pending_divisors.pop_front();
                divisors_checked++;
                if (result.integer_divisor !== want.integer_divisor)
                begin
                    $error("integer_divisor: expected %0d, actual %0d",
                           want.integer_divisor, result.integer_divisor);
                    failures++;
                end
                if (result.fraction_divisor !== want.fraction_divisor)
                begin
                    $error("fraction_divisor: expected %0d, actual %0d",
                           want.fraction_divisor, result.fraction_divisor);
                    failures++;
                end
            end
        end
    end

    // A zero clock or a zero baud rate must give the safe pair of one and zero.
    task automatic test_zero_operands();
        issue_request(32'd0, 32'd0);
        issue_request(32'd0, 32'd115200);
        issue_request(32'd0, ALL_ONES);
        issue_request(32'd48_000_000, 32'd0);
        issue_request(ALL_ONES, 32'd0);
    endtask

    // Field extremes, including the largest integer divisor the unit can produce, and
    // alternating bit patterns so every input bit is seen at both values.
    task automatic test_field_extremes();
        issue_request(ALL_ONES, 32'd1);
        issue_request(ALL_ONES, ALL_ONES);
        issue_request(32'd1, 32'd1);
        issue_request(ALL_ONES, 32'd2);
        issue_request(32'd16, 32'd1);
        issue_request(32'd15, 32'd1);
        issue_request(32'hAAAA_AAAA, 32'h5555_5555);
        issue_request(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // A clock below sixteen times the baud: the integer divisor is forced up to one
    // while the fraction still comes from the whole clock.
    task automatic test_clamped_integer();
        issue_request(32'd1, ALL_ONES);
        issue_request(32'd1000, 32'd115200);
    endtask

    // Remainders so close to the denominator that rounding would reach 64; the
    // fraction must stop at 63 and the integer part must not move.
    task automatic test_fraction_saturation();
        issue_request(32'd111_999, 32'd1000);
        issue_request(32'd15_999, 32'd1000);
        issue_request(32'd16_000 * 32'd200 + 32'd15_990, 32'd1000);
    endtask

    // A handful of ordinary clock and baud combinations.
    task automatic test_common_rates();
        issue_request(32'd48_000_000, 32'd115_200);
        issue_request(32'd24_000_000, 32'd9_600);
        issue_request(32'd3_686_400, 32'd115_200);
        issue_request(32'd100_000_000, 32'd921_600);
        issue_request(32'd50_000_000, 32'd3_000_000);
    endtask

    // Random traffic weighted toward realistic settings and toward the corners that
    // exercise rounding and clamping. One long stretch runs with start held high.
    task automatic test_random_traffic();
        longint unsigned baud;
        longint unsigned denom;
        longint unsigned max_quot;
        longint unsigned quot;
        longint unsigned clk_freq;
        longint unsigned upper;
        int              pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_enabled = !(n >= 400 && n < 600);
            pick = $urandom_range(99, 0);
            if (pick < 40)
            begin
                issue_request($urandom_range(250_000_000, 1_000_000),
                              $urandom_range(4_000_000, 50));
            end
            else if (pick < 55)
            begin
                // Remainder just short of the denominator, so the fraction saturates.
                baud     = $urandom_range(32'h0040_0000, 1);
                denom    = OVERSAMPLE * baud;
                max_quot = (longint'(ALL_ONES) - denom) / denom;
                quot     = $urandom_range((max_quot > 4095) ? 4095 : max_quot, 0);
                clk_freq = quot * denom + denom - 1 - $urandom_range(baud / 16, 0);
                issue_request(clk_freq[31:0], baud[31:0]);
            end
            else if (pick < 70)
            begin
                issue_request($urandom, $urandom);
            end
            else if (pick < 80)
            begin
                // Clock below the denominator, so the integer part is clamped.
                baud  = $urandom_range(32'h0FFF_FFFF, 1);
                upper = OVERSAMPLE * baud - 1;
                if (upper > longint'(ALL_ONES))
                begin
                    upper = longint'(ALL_ONES);
                end
                issue_request($urandom_range(upper[31:0], 1), baud[31:0]);
            end
            else if (pick < 90)
            begin
                issue_request($urandom_range(255, 0), $urandom_range(255, 0));
            end
            else if (pick < 95)
            begin
                if ($urandom_range(1, 0) == 1)
                begin
                    issue_request(32'd0, $urandom);
                end
                else
                begin
                    issue_request($urandom, 32'd0);
                end
            end
            else
            begin
                issue_request(ALL_ONES - $urandom_range(255, 0), $urandom_range(16, 1));
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        start                 = 1'b0;
        request               = '0;
        failures              = 0;
        requests_accepted     = 0;
        divisors_checked      = 0;
        saturated_fractions   = 0;
        zero_operand_requests = 0;
        gaps_enabled          = 1'b1;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_zero_operands();
        test_field_extremes();
        test_clamped_integer();
        test_fraction_saturation();
        test_common_rates();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;

        // Wait for every outstanding result, then watch a while longer for strays.
        while (pending_divisors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d checked results.",
                 requests_accepted, divisors_checked);
        $display("Of those, %0d had a zero operand and %0d a saturated fraction.",
                 zero_operand_requests, saturated_fractions);
        if (failures == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
